// ----- rtl/alm_pkg.sv -----
// Shared constants and types for the array linked list manager.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
package alm_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam ptr_t FREE_HEAD = '0;
  localparam ptr_t LIST_HEAD = ptr_t'(DEPTH - 1);

endpackage

// ----- rtl/alm_ifs.sv -----
// Valid/ready channel interfaces for command items and result items.
// Depends on alm_pkg for field widths.
`timescale 1ns / 1ps
interface alm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic        [alm_pkg::POS_W-1:0]    position;
  logic signed [alm_pkg::VAL_W-1:0]    value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

interface alm_out_if;
  logic                          valid;
  logic                          ready;
  alm_pkg::status_t              status;
  logic [alm_pkg::POS_W-1:0]     list_length;

  modport source (output valid, output status, output list_length, input ready);
  modport sink   (input valid, input status, input list_length, output ready);
endinterface

// ----- rtl/array_linked_list_manager.sv -----
// Cursor-linked list in a link memory with a free chain; insert/delete by position.
// Depends on alm_pkg and the channel interfaces in alm_ifs.sv.
//
//   channel | dir | payload                          | handshake
//   in_ch   | in  | command, position, value         | valid & ready
//   out_ch  | out | status, list_length              | valid & ready
//
// After reset a clearing pass writes the free chain into all DEPTH (1024) link entries, in_ch not ready.
// One item at a time: a bad position goes straight to its result, a full insert after one free head read;
// insert and delete walk the list from its head, one link memory read per node walked.
// A finished result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
module array_linked_list_manager (
  input  logic             clk,
  input  logic             rst_n,
  alm_in_if.sink           in_ch,
  alm_out_if.source        out_ch
);

  localparam logic [3:0] S_INIT      = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_GOT_FREE  = 4'd2;
  localparam logic [3:0] S_GOT_FNEXT = 4'd3;
  localparam logic [3:0] S_STEP      = 4'd4;
  localparam logic [3:0] S_INS_B     = 4'd5;
  localparam logic [3:0] S_DEL_A     = 4'd6;
  localparam logic [3:0] S_DEL_B     = 4'd7;
  localparam logic [3:0] S_DEL_C     = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  alm_pkg::ptr_t  link_mem [alm_pkg::DEPTH];
  logic signed [alm_pkg::VAL_W-1:0] data_mem [alm_pkg::DEPTH];

  logic [3:0]                  state_r, state_nxt;
  alm_pkg::ptr_t               clr_r, clr_nxt;
  alm_pkg::ptr_t               cur_r, cur_nxt;
  alm_pkg::ptr_t               node_r, node_nxt;
  alm_pkg::ptr_t               prev_r, prev_nxt;
  logic [alm_pkg::POS_W-1:0]   cnt_r, cnt_nxt;
  logic [alm_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        cmd_r, cmd_nxt;
  logic signed [alm_pkg::VAL_W-1:0] val_r, val_nxt;
  alm_pkg::status_t            status_r, status_nxt;
  logic [alm_pkg::POS_W-1:0]   count_r, count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  alm_pkg::status_t            out_status_r, out_status_nxt;
  logic [alm_pkg::POS_W-1:0]   out_len_r, out_len_nxt;

  logic                        lk_we;
  alm_pkg::ptr_t               lk_waddr, lk_wdata, lk_raddr, lk_rdata_r;
  logic                        dt_we;
  logic                        accept;
  logic                        bad_pos;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.list_length = out_len_r;

  always_comb begin
    if (in_ch.command == alm_pkg::CMD_INSERT) begin
      bad_pos = (in_ch.position == '0) ||
                ({1'b0, in_ch.position} > ({1'b0, count_r} + 11'd1));
    end else begin
      bad_pos = (in_ch.position == '0) || (in_ch.position > count_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    node_nxt       = node_r;
    prev_nxt       = prev_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    lk_we          = 1'b0;
    lk_waddr       = clr_r;
    lk_wdata       = '0;
    lk_raddr       = cur_r;
    dt_we          = 1'b0;

    case (state_r)
      S_INIT: begin
        lk_we    = 1'b1;
        lk_waddr = clr_r;
        lk_wdata = (clr_r < alm_pkg::ptr_t'(alm_pkg::DEPTH - 2)) ? clr_r + 1'b1 : '0;
        if (clr_r == alm_pkg::ptr_t'(alm_pkg::DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          pos_nxt = in_ch.position;
          cmd_nxt = in_ch.command;
          val_nxt = in_ch.value;
          if (bad_pos) begin
            status_nxt = alm_pkg::ST_RANGE;
            state_nxt  = S_DONE;
          end else if (in_ch.command == alm_pkg::CMD_INSERT) begin
            lk_raddr  = alm_pkg::FREE_HEAD;
            state_nxt = S_GOT_FREE;
          end else begin
            lk_raddr  = alm_pkg::LIST_HEAD;
            cur_nxt   = alm_pkg::LIST_HEAD;
            cnt_nxt   = alm_pkg::POS_W'(1);
            state_nxt = S_STEP;
          end
        end
      end
      S_GOT_FREE: begin
        if (lk_rdata_r == alm_pkg::FREE_HEAD) begin
          status_nxt = alm_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          node_nxt  = lk_rdata_r;
          lk_raddr  = lk_rdata_r;
          state_nxt = S_GOT_FNEXT;
        end
      end
      S_GOT_FNEXT: begin
        lk_we     = 1'b1;
        lk_waddr  = alm_pkg::FREE_HEAD;
        lk_wdata  = lk_rdata_r;
        dt_we     = 1'b1;
        lk_raddr  = alm_pkg::LIST_HEAD;
        cur_nxt   = alm_pkg::LIST_HEAD;
        cnt_nxt   = alm_pkg::POS_W'(1);
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (cnt_r == pos_r) begin
          prev_nxt = cur_r;
          if (cmd_r == alm_pkg::CMD_INSERT) begin
            lk_we     = 1'b1;
            lk_waddr  = node_r;
            lk_wdata  = lk_rdata_r;
            state_nxt = S_INS_B;
          end else begin
            node_nxt  = lk_rdata_r;
            lk_raddr  = lk_rdata_r;
            state_nxt = S_DEL_A;
          end
        end else begin
          cur_nxt  = lk_rdata_r;
          cnt_nxt  = cnt_r + 1'b1;
          lk_raddr = lk_rdata_r;
        end
      end
      S_INS_B: begin
        lk_we      = 1'b1;
        lk_waddr   = prev_r;
        lk_wdata   = node_r;
        count_nxt  = count_r + 1'b1;
        status_nxt = alm_pkg::ST_OK;
        state_nxt  = S_DONE;
      end
      S_DEL_A: begin
        lk_we     = 1'b1;
        lk_waddr  = prev_r;
        lk_wdata  = lk_rdata_r;
        lk_raddr  = alm_pkg::FREE_HEAD;
        state_nxt = S_DEL_B;
      end
      S_DEL_B: begin
        lk_we     = 1'b1;
        lk_waddr  = node_r;
        lk_wdata  = lk_rdata_r;
        state_nxt = S_DEL_C;
      end
      S_DEL_C: begin
        lk_we      = 1'b1;
        lk_waddr   = alm_pkg::FREE_HEAD;
        lk_wdata   = node_r;
        count_nxt  = count_r - 1'b1;
        status_nxt = alm_pkg::ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_len_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    lk_rdata_r <= link_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (dt_we) begin
      data_mem[node_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    node_r       <= node_nxt;
    prev_r       <= prev_nxt;
    cnt_r        <= cnt_nxt;
    pos_r        <= pos_nxt;
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

endmodule

// ----- rtl/alm_checker.sv -----
// Port-level checks for array_linked_list_manager, attached by bind.
// Depends on alm_pkg.
`timescale 1ns / 1ps
module alm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input alm_pkg::status_t            out_status,
  input logic [alm_pkg::POS_W-1:0]   out_list_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_list_length <= alm_pkg::POS_W'(alm_pkg::DEPTH - 2))
    else $error("list length beyond node capacity");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == alm_pkg::ST_OK || out_status == alm_pkg::ST_RANGE ||
                   out_status == alm_pkg::ST_FULL))
    else $error("undefined status code");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("item taken while previous item still at work");

endmodule

bind array_linked_list_manager alm_checker u_alm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_list_length (out_ch.list_length)
);
